FILE: rtl/assert_macros.svh
// Assertion macros used by the port-level checker of the URL percent decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is asserted.
`define URLPD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define URLPD_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/urlpd_pkg.sv
// Types, constants and helper functions of the URL percent decoder.
`default_nettype none

package urlpd_pkg;

	// Register map
	localparam int ADDR_W = 3;
	localparam logic [ADDR_W-3:0] REG_MAX_LENGTH = '0;
	localparam int LEN_W = 13;
	localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 13'd64;

	// Characters with a meaning of their own
	localparam logic [7:0] CH_AMP = 8'h26;
	localparam logic [7:0] CH_PCT = 8'h25;
	localparam logic [7:0] CH_NUL = 8'h00;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_9 = 8'h39;
	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_UF = 8'h46;
	localparam logic [7:0] CH_LA = 8'h61;
	localparam logic [7:0] CH_LF = 8'h66;
	localparam logic [3:0] HEX_TEN = 4'd10;

	typedef enum logic [2:0] {
		ST_RUN = 3'd0,
		ST_AMP = 3'd1,
		ST_NUL = 3'd2,
		ST_TRUNC = 3'd3,
		ST_ERR = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		MODE_NORMAL = 2'd0,
		MODE_HEX1 = 2'd1,
		MODE_HEX2 = 2'd2
	} mode_t;

	typedef struct packed {
		logic ok;
		logic [3:0] val;
	} hex_t;

	// One decode step's result
	typedef struct packed {
		logic has;
		logic [7:0] data_byte;
		logic data_valid;
		logic last;
		status_t status;
	} res_t;

	// Value of one hex digit, either case
	function automatic hex_t hex_value(input logic [7:0] ch);
		hex_t h;
		logic [7:0] d;
		h = '0;
		d = '0;
		if (ch inside {[CH_0:CH_9]}) begin
			d = ch - CH_0;
			h.ok = 1'b1;
			h.val = d[3:0];
		end else if (ch inside {[CH_UA:CH_UF]}) begin
			d = ch - CH_UA;
			h.ok = 1'b1;
			h.val = d[3:0] + HEX_TEN;
		end else if (ch inside {[CH_LA:CH_LF]}) begin
			d = ch - CH_LA;
			h.ok = 1'b1;
			h.val = d[3:0] + HEX_TEN;
		end
		return h;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/urlpd_apb.sv
// APB-style configuration register bank of the URL percent decoder.
`default_nettype none

module urlpd_apb (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [urlpd_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output logic [urlpd_pkg::LEN_W-1:0] max_length
);

	logic [urlpd_pkg::LEN_W-1:0] max_length_q;
	logic hit;

	assign hit = (paddr[urlpd_pkg::ADDR_W-1:2] == urlpd_pkg::REG_MAX_LENGTH);
	assign pready = 1'b1;

	// Register write in the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= urlpd_pkg::MAX_LENGTH_RESET;
		end else if (psel && penable && pwrite && hit) begin
			max_length_q <= pwdata[urlpd_pkg::LEN_W-1:0];
		end
	end

	// Read back
	always_comb begin
		prdata = '0;
		if (hit) begin
			prdata = {{(32 - urlpd_pkg::LEN_W){1'b0}}, max_length_q};
		end
	end

	assign max_length = max_length_q;

endmodule

`default_nettype wire

FILE: rtl/urlpd_decode.sv
// Field state and per-character decode step of the URL percent decoder.
`default_nettype none

module urlpd_decode (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic step,
	input  wire logic [7:0] ch,
	input  wire logic [urlpd_pkg::LEN_W-1:0] max_length,
	output urlpd_pkg::res_t res
);

	urlpd_pkg::mode_t mode_q, mode_d;
	logic [3:0] nibble_q, nibble_d;
	logic bad_q, bad_d;
	logic [urlpd_pkg::LEN_W-1:0] cnt_q, cnt_d;
	logic [urlpd_pkg::LEN_W:0] cnt_p1, cnt_p2, max_ext;
	urlpd_pkg::hex_t hx;

	assign cnt_p1 = {1'b0, cnt_q} + 1'b1;
	assign cnt_p2 = {1'b0, cnt_q} + 2'd2;
	assign max_ext = {1'b0, max_length};
	assign hx = urlpd_pkg::hex_value(ch);

	// Field state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= urlpd_pkg::MODE_NORMAL;
			nibble_q <= '0;
			bad_q <= 1'b0;
			cnt_q <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			nibble_q <= nibble_d;
			bad_q <= bad_d;
			cnt_q <= cnt_d;
		end
	end

	// Next state and result of one character
	always_comb begin
		mode_d = mode_q;
		nibble_d = nibble_q;
		bad_d = bad_q;
		cnt_d = cnt_q;
		res = '0;
		res.status = urlpd_pkg::ST_RUN;
		case (mode_q)
			urlpd_pkg::MODE_HEX1: begin
				cnt_d = cnt_p1[urlpd_pkg::LEN_W-1:0];
				if (ch == urlpd_pkg::CH_NUL) begin
					res.has = 1'b1;
					res.last = 1'b1;
					res.status = urlpd_pkg::ST_ERR;
				end else begin
					bad_d = bad_q | !hx.ok;
					nibble_d = hx.ok ? hx.val : 4'd0;
					mode_d = urlpd_pkg::MODE_HEX2;
				end
			end
			urlpd_pkg::MODE_HEX2: begin
				cnt_d = cnt_p1[urlpd_pkg::LEN_W-1:0];
				res.has = 1'b1;
				mode_d = urlpd_pkg::MODE_NORMAL;
				if (ch == urlpd_pkg::CH_NUL || !hx.ok || bad_q) begin
					res.last = 1'b1;
					res.status = urlpd_pkg::ST_ERR;
				end else begin
					res.data_byte = {nibble_q, hx.val};
					res.data_valid = 1'b1;
					// count compared after wrapping to the register width
					if ({1'b0, cnt_p1[urlpd_pkg::LEN_W-1:0]} >= max_ext) begin
						res.last = 1'b1;
						res.status = urlpd_pkg::ST_TRUNC;
					end
				end
			end
			default: begin
				// normal mode, also the unused mode code
				mode_d = urlpd_pkg::MODE_NORMAL;
				if (ch == urlpd_pkg::CH_AMP) begin
					res.has = 1'b1;
					res.last = 1'b1;
					res.status = urlpd_pkg::ST_AMP;
				end else if (ch == urlpd_pkg::CH_NUL) begin
					res.has = 1'b1;
					res.last = 1'b1;
					res.status = urlpd_pkg::ST_NUL;
				end else if (ch == urlpd_pkg::CH_PCT) begin
					if (cnt_p2 >= max_ext) begin
						res.has = 1'b1;
						res.last = 1'b1;
						res.status = urlpd_pkg::ST_ERR;
					end else begin
						cnt_d = cnt_p1[urlpd_pkg::LEN_W-1:0];
						mode_d = urlpd_pkg::MODE_HEX1;
						bad_d = 1'b0;
						nibble_d = '0;
					end
				end else begin
					cnt_d = cnt_p1[urlpd_pkg::LEN_W-1:0];
					res.has = 1'b1;
					res.data_byte = ch;
					res.data_valid = 1'b1;
					if (cnt_p1 >= max_ext) begin
						res.last = 1'b1;
						res.status = urlpd_pkg::ST_TRUNC;
					end
				end
			end
		endcase
		// any field end starts a new field
		if (res.last) begin
			mode_d = urlpd_pkg::MODE_NORMAL;
			nibble_d = '0;
			bad_d = 1'b0;
			cnt_d = '0;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/url_percent_decoder_top.sv
// Top level of the streaming URL percent decoder.
`default_nettype none

// Streaming URL percent decoder: one source character per transfer on the input
// channel, at most one result per character on the output channel. Plain
// characters pass through, "%hh" gives one byte, '&' or NUL ends the field, and
// the field ends truncated or with an error against the max_length register
// (byte address 0, reset 64). Throughput is one character per clock cycle,
// sustained under any stall pattern that leaves the output free; a character
// passes through the input register and then the result register. The rate is
// set by the field state update in the decode stage. No clearing pass is
// needed after reset. Write max_length only while idle.
module url_percent_decoder_top (
	input  wire logic clk,
	input  wire logic arst_n,
	// configuration
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [urlpd_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	// input channel
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [7:0] char_in,
	// output channel
	output logic out_valid,
	input  wire logic out_stall,
	output logic [7:0] data_byte,
	output logic data_valid,
	output logic last,
	output logic [2:0] status
);

	logic [urlpd_pkg::LEN_W-1:0] max_length;
	logic valid_s1;
	logic [7:0] char_s1;
	logic advance;
	urlpd_pkg::res_t res;
	logic out_valid_q;
	urlpd_pkg::res_t res_q;

	urlpd_apb u_apb (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.max_length(max_length)
	);

	// The decode stage moves on when the result register is free or drains now
	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_in;
		end
	end

	urlpd_decode u_decode (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.ch(char_s1),
		.max_length(max_length),
		.res(res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res.has;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.has) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign data_byte = res_q.data_byte;
	assign data_valid = res_q.data_valid;
	assign last = res_q.last;
	assign status = res_q.status;

endmodule

`default_nettype wire

FILE: rtl/urlpd_checker.sv
// Port-level checks of the URL percent decoder and their bind to the top level.
`default_nettype none

`include "assert_macros.svh"

module urlpd_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_stall,
	input wire logic [7:0] data_byte,
	input wire logic data_valid,
	input wire logic last,
	input wire logic [2:0] status
);

	// a stalled result holds
	`URLPD_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(data_valid) && $stable(last) && $stable(status), "stalled result changed")

	// a result with no byte always ends the field and carries a zero byte
	`URLPD_ASSERT(a_nobyte_ends, out_valid && !data_valid |-> last && (data_byte == 8'd0), "byteless result does not end field")

	// last is set exactly when the status is not running
	`URLPD_ASSERT(a_last_status, out_valid |-> (last == (status != urlpd_pkg::ST_RUN)), "last and status disagree")

	// ampersand, NUL and error ends carry no byte
	`URLPD_ASSERT(a_end_nobyte, out_valid && (status == urlpd_pkg::ST_AMP || status == urlpd_pkg::ST_NUL || status == urlpd_pkg::ST_ERR) |-> !data_valid, "byte on a non-data end")

	// no result while in reset
	`URLPD_ASSERT_RST(a_reset_idle, !arst_n |-> !out_valid, "result during reset")

endmodule

bind url_percent_decoder_top urlpd_checker u_urlpd_checker (.*);

`default_nettype wire

FILE: verif/urlpd_stream_checker.sv
// Checker for the URL percent decoder: tracks field state, predicts results, compares them.
module urlpd_stream_checker
	import urlpd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	input  logic pready,
	input  logic in_valid,
	input  logic in_stall,
	input  logic [7:0] char_in,
	input  logic out_valid,
	input  logic out_stall,
	input  logic [7:0] data_byte,
	input  logic data_valid,
	input  logic last,
	input  logic [2:0] status,
	output int fail_count,
	output int outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [ADDR_W-1:0] LIMIT_ADDR = {REG_MAX_LENGTH, 2'b00};

	// Shadow of the decoder's field state and its length register
	mode_t field_mode;
	logic [3:0] nibble_hi;
	logic first_bad;
	logic [LEN_W-1:0] field_count;
	logic [LEN_W-1:0] length_limit;

	res_t decoded_q[$];
	res_t want;
	res_t pred;
	int fails;

	// Hex digit value, -1 when the character is no hex digit
	function automatic int digit_of(input logic [7:0] ch);
		if (ch >= CH_0 && ch <= CH_9) return int'(ch - CH_0);
		if (ch >= CH_UA && ch <= CH_UF) return int'(ch - CH_UA) + 10;
		if (ch >= CH_LA && ch <= CH_LF) return int'(ch - CH_LA) + 10;
		return -1;
	endfunction

	// Advance the field state by one character; returns the result it causes, if any
	function automatic res_t decode_char(input logic [7:0] ch);
		res_t r;
		int cnt;
		int dig;
		r = '0;
		r.status = ST_RUN;
		cnt = int'(field_count);
		dig = digit_of(ch);
		case (field_mode)
			MODE_HEX1: begin
				field_count = field_count + 1'b1;
				if (ch == CH_NUL) begin
					r.has = 1'b1;
					r.last = 1'b1;
					r.status = ST_ERR;
				end else begin
					// a bad first digit is only reported after the second one
					first_bad = (dig < 0);
					nibble_hi = (dig < 0) ? 4'd0 : dig[3:0];
					field_mode = MODE_HEX2;
				end
			end
			MODE_HEX2: begin
				field_count = field_count + 1'b1;
				r.has = 1'b1;
				if (ch == CH_NUL || dig < 0 || first_bad) begin
					r.last = 1'b1;
					r.status = ST_ERR;
				end else begin
					field_mode = MODE_NORMAL;
					r.data_byte = {nibble_hi, dig[3:0]};
					r.data_valid = 1'b1;
					if (field_count >= length_limit) begin
						r.last = 1'b1;
						r.status = ST_TRUNC;
					end
				end
			end
			default: begin
				field_mode = MODE_NORMAL;
				if (ch == CH_AMP) begin
					r.has = 1'b1;
					r.last = 1'b1;
					r.status = ST_AMP;
				end else if (ch == CH_NUL) begin
					r.has = 1'b1;
					r.last = 1'b1;
					r.status = ST_NUL;
				end else if (ch == CH_PCT) begin
					// an escape needs room for both digits
					if (cnt + 2 >= int'(length_limit)) begin
						r.has = 1'b1;
						r.last = 1'b1;
						r.status = ST_ERR;
					end else begin
						field_count = field_count + 1'b1;
						field_mode = MODE_HEX1;
						first_bad = 1'b0;
						nibble_hi = 4'd0;
					end
				end else begin
					field_count = field_count + 1'b1;
					r.has = 1'b1;
					r.data_byte = ch;
					r.data_valid = 1'b1;
					if (cnt + 1 >= int'(length_limit)) begin
						r.last = 1'b1;
						r.status = ST_TRUNC;
					end
				end
			end
		endcase
		// any end of field starts a new one
		if (r.last) begin
			field_mode = MODE_NORMAL;
			nibble_hi = 4'd0;
			first_bad = 1'b0;
			field_count = '0;
		end
		return r;
	endfunction

	// Watch register writes and both channels at each edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			field_mode = MODE_NORMAL;
			nibble_hi = 4'd0;
			first_bad = 1'b0;
			field_count = '0;
			length_limit = MAX_LENGTH_RESET;
			decoded_q.delete();
			fails = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == LIMIT_ADDR)
				length_limit = pwdata[LEN_W-1:0];

			// result transfer: compare with the oldest prediction
			if (out_valid && !out_stall) begin
				if (decoded_q.size() == 0) begin
					$error("unexpected result: data_byte %02h data_valid %0d last %0d status %0d",
						data_byte, data_valid, last, status);
					fails++;
				end else begin
					want = decoded_q.pop_front();
					if (data_byte !== want.data_byte) begin
						$error("data_byte: expected %02h, got %02h", want.data_byte, data_byte);
						fails++;
					end
					if (data_valid !== want.data_valid) begin
						$error("data_valid: expected %0d, got %0d", want.data_valid, data_valid);
						fails++;
					end
					if (last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, last);
						fails++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						fails++;
					end
				end
			end

			// character transfer: predict what it causes
			if (in_valid && !in_stall) begin
				pred = decode_char(char_in);
				if (pred.has)
					decoded_q.push_back(pred);
			end

			fail_count <= fails;
			outstanding <= decoded_q.size();
		end
	end

endmodule

FILE: verif/url_percent_decoder_top_tb.sv
// Testbench top for the URL percent decoder: clock, reset, stimulus and verdict.
module url_percent_decoder_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import urlpd_pkg::*;

	localparam logic [ADDR_W-1:0] LIMIT_ADDR = {REG_MAX_LENGTH, 2'b00};
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 6;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 60;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	logic [7:0] char_in;
	logic out_valid;
	logic out_stall;
	logic [7:0] data_byte;
	logic data_valid;
	logic last;
	logic [2:0] status;

	int fail_count;
	int outstanding;
	int items_sent;
	int cycle_count;
	logic calm;
	int phase_limit[PHASES];

	// Plain text, escapes in both cases, both terminators, and broken escapes
	logic [7:0] opening_chars[$] = '{
		8'h61, CH_PCT, 8'h34, 8'h31, CH_PCT, 8'h61, 8'h46, CH_AMP,
		CH_NUL, CH_PCT, CH_0, CH_0, CH_PCT, 8'h67, 8'h31, CH_PCT,
		8'h31, 8'h7A, CH_PCT, CH_NUL, 8'hFF, CH_PCT, 8'h34, CH_NUL
	};

	url_percent_decoder_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_in(char_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_byte(data_byte),
		.data_valid(data_valid),
		.last(last),
		.status(status)
	);

	urlpd_stream_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_in(char_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.data_byte(data_byte),
		.data_valid(data_valid),
		.last(last),
		.status(status),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver stalls at random, except during the calm stretch
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 11);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("url_percent_decoder_top: mismatch");
			$finish;
		end
	end

	function automatic logic is_hex(input logic [7:0] ch);
		return (ch >= CH_0 && ch <= CH_9) || (ch >= CH_UA && ch <= CH_UF) ||
			(ch >= CH_LA && ch <= CH_LF);
	endfunction

	// Hex digit for a nibble, upper or lower case
	function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
		if (v < HEX_TEN) return CH_0 + 8'(v);
		return (upper ? CH_UA : CH_LA) + 8'(v - HEX_TEN);
	endfunction

	function automatic logic [7:0] plain_char();
		logic [7:0] c;
		do c = 8'($urandom_range(1, 255)); while (c == CH_PCT || c == CH_AMP);
		return c;
	endfunction

	function automatic logic [7:0] non_hex_char();
		logic [7:0] c;
		do c = 8'($urandom_range(255)); while (is_hex(c));
		return c;
	endfunction

	// One character transfer, after a random gap
	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = 0;
		if (!calm)
			while ($urandom_range(99) < 11) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		char_in <= c;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// One field: mostly well-formed, sometimes a broken escape or raw noise
	task automatic send_field(input int limit);
		int kind;
		int span;
		int tokens;
		int pick;
		kind = $urandom_range(99);
		if (kind < 78) begin
			span = (limit > 12) ? 12 : limit + 2;
			tokens = $urandom_range(span);
			repeat (tokens) begin
				if ($urandom_range(2) == 0) begin
					send_char(CH_PCT);
					send_char(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
					send_char(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
				end else begin
					send_char(plain_char());
				end
			end
			pick = $urandom_range(9);
			if (pick < 5)
				send_char(CH_AMP);
			else if (pick < 8)
				send_char(CH_NUL);
		end else if (kind < 90) begin
			send_char(CH_PCT);
			pick = $urandom_range(3);
			case (pick)
				0: send_char(CH_NUL);
				1: begin
					send_char(non_hex_char());
					send_char(8'($urandom_range(255)));
				end
				2: begin
					send_char(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
					send_char(($urandom_range(3) == 0) ? CH_NUL : non_hex_char());
				end
				default: begin
					send_char(non_hex_char());
					send_char(hex_char(4'($urandom_range(15)), 1'($urandom_range(1))));
				end
			endcase
		end else begin
			repeat ($urandom_range(1, 6)) send_char(8'($urandom_range(255)));
		end
	endtask

	// Stop sending, wait for every predicted result, then let the pipeline empty
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input int value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LIMIT_ADDR;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	initial begin
		int phase_end;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		char_in = '0;
		out_stall = 1'b0;
		calm = 1'b0;
		items_sent = 0;
		cycle_count = 0;
		phase_limit = '{1, 2, 3, $urandom_range(4, 12), 4096, $urandom_range(13, 40), 64,
			$urandom_range(1, 8)};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed characters at the reset limit
		foreach (opening_chars[i])
			send_char(opening_chars[i]);

		// random phases, each under its own length limit
		for (int p = 0; p < PHASES; p++) begin
			settle();
			write_limit(phase_limit[p]);
			calm <= (p == 5);
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end)
				send_field(phase_limit[p]);
		end

		settle();
		if (outstanding != 0)
			$error("%0d predicted results never arrived", outstanding);
		if (fail_count == 0 && outstanding == 0)
			$display("url_percent_decoder_top: match");
		else
			$display("url_percent_decoder_top: mismatch");
		$finish;
	end

endmodule
